### src/ofsa_pkg.sv
`default_nettype none
package ofsa_pkg;

    // Table sizes.
    localparam int DESCRIPTORS  = 32;
    localparam int FILE_ENTRIES = 64;

    // Index widths, at least one bit even for a single-slot table.
    localparam int DIDX_W = (DESCRIPTORS > 1) ? $clog2(DESCRIPTORS) : 1;
    localparam int EIDX_W = (FILE_ENTRIES > 1) ? $clog2(FILE_ENTRIES) : 1;

    // Reference counts saturate at the largest value of their field.
    localparam int               COUNT_W   = 6;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        CMD_OPEN   = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_DUP    = 2'd2,
        CMD_CLOSE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADF   = 2'd1,
        ST_NODESC = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // Write into the descriptor map.
    typedef struct packed {
        logic              en;
        logic [DIDX_W-1:0] idx;
        logic              valid;
        logic [EIDX_W-1:0] entry;
    } t_map_wr;

    // Write into the reference count memory.
    typedef struct packed {
        logic               en;
        logic [EIDX_W-1:0]  addr;
        logic [COUNT_W-1:0] data;
    } t_cnt_wr;

endpackage
`default_nettype wire

### src/ofsa_desc_map.sv
`default_nettype none
module ofsa_desc_map (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire ofsa_pkg::t_map_wr         i_wr,
    input  wire logic [ofsa_pkg::DIDX_W-1:0] i_chk_idx,
    output logic                           o_chk_free,
    input  wire logic [ofsa_pkg::DIDX_W-1:0] i_rd_idx,
    output logic                           o_rd_valid,
    output logic [ofsa_pkg::EIDX_W-1:0]    o_rd_entry
);
    import ofsa_pkg::*;

    logic [DESCRIPTORS-1:0] r_vld;
    logic [EIDX_W-1:0]      r_ent [DESCRIPTORS];

    // Valid bits clear at reset; entry fields are only read behind a valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.idx] <= i_wr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_ent[i_wr.idx] <= i_wr.entry;
        end
    end

    assign o_chk_free = !r_vld[i_chk_idx];
    assign o_rd_valid = r_vld[i_rd_idx];
    assign o_rd_entry = r_ent[i_rd_idx];

endmodule
`default_nettype wire

### src/ofsa_count_ram.sv
`default_nettype none
module ofsa_count_ram (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ofsa_pkg::t_cnt_wr            i_wr,
    input  wire logic [ofsa_pkg::EIDX_W-1:0]  i_rd_addr,
    output logic [ofsa_pkg::COUNT_W-1:0]      o_rd_data
);
    import ofsa_pkg::*;

    logic [COUNT_W-1:0]      r_mem [FILE_ENTRIES];
    logic [FILE_ENTRIES-1:0] r_vld;
    logic [COUNT_W-1:0]      r_rd_data;
    logic                    r_rd_vld;

    // An entry never written since reset reads as a zero count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
`default_nettype wire

### src/open_file_slot_allocator.sv
`default_nettype none
// Open file slot allocator: a descriptor map whose slots point at shared
// entries, each entry keeping a reference count.
//
// A command word is taken at a rising edge where start is high and busy is
// low. It carries the command (open, lookup, duplicate, close) and, for all
// but open, a descriptor. Exactly one result word follows on o_status,
// o_descriptor_out, o_entry_out and o_last_close, marked by o_valid for one
// cycle; the receiver cannot hold it off, and busy falls in that same cycle,
// so the next command can be started while the result is shown.
//
// Duplicate and open search for the lowest free descriptor, one map slot
// checked per cycle; open then searches the entries next-fit, issuing one
// count read per cycle to a memory with registered read data, until a free
// entry is found or every entry has been read, which answers full.
// Reset (synchronous, active low) marks all descriptors free, all counts
// zero through per-entry valid bits, and the next-fit start as entry zero.
// The block is ready as soon as reset is released; no clearing pass runs.
module open_file_slot_allocator (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire ofsa_pkg::t_cmd         i_command,
    input  wire logic [7:0]             i_descriptor,
    output logic                        o_valid,
    output ofsa_pkg::t_status           o_status,
    output logic [4:0]                  o_descriptor_out,
    output logic [5:0]                  o_entry_out,
    output logic                        o_last_close
);
    import ofsa_pkg::*;

    // The entry scan counter must hold the table size itself.
    localparam int IK_W = $clog2(FILE_ENTRIES + 1);
    localparam logic [8:0]        DLIM      = 9'(DESCRIPTORS);
    localparam logic [DIDX_W-1:0] DLAST     = DIDX_W'(DESCRIPTORS - 1);
    localparam logic [EIDX_W-1:0] ELAST     = EIDX_W'(FILE_ENTRIES - 1);
    localparam logic [IK_W-1:0]   ECOUNT    = IK_W'(FILE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESOLVE,
        S_DSCAN,
        S_CRD,
        S_CWAIT,
        S_ESCAN
    } t_state;

    // Next entry index in ring order.
    function automatic logic [EIDX_W-1:0] ent_inc(input logic [EIDX_W-1:0] e);
        ent_inc = (e == ELAST) ? '0 : e + EIDX_W'(1);
    endfunction

    t_state             r_state;
    t_cmd               r_cmd;
    logic [7:0]         r_dsc;
    logic [EIDX_W-1:0]  r_ent;
    logic [DIDX_W-1:0]  r_dscan;
    logic [DIDX_W-1:0]  r_dfree;
    logic [EIDX_W-1:0]  r_eaddr;
    logic [IK_W-1:0]    r_issue_k;
    logic               r_pend;
    logic [EIDX_W-1:0]  r_pend_addr;
    logic [EIDX_W-1:0]  r_next_start;
    logic               r_valid;
    t_status            r_status;
    logic [4:0]         r_dout;
    logic [5:0]         r_eout;
    logic               r_last;

    t_map_wr            map_wr;
    t_cnt_wr            cnt_wr;
    logic               chk_free;
    logic               rd_valid;
    logic [EIDX_W-1:0]  rd_entry;
    logic [EIDX_W-1:0]  cnt_addr;
    logic [COUNT_W-1:0] cnt_data;
    logic               dsc_in_range;
    logic               cnt_free;
    logic               cnt_sat;
    logic               cnt_last;

    ofsa_desc_map u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (map_wr),
        .i_chk_idx  (r_dscan),
        .o_chk_free (chk_free),
        .i_rd_idx   (r_dsc[DIDX_W-1:0]),
        .o_rd_valid (rd_valid),
        .o_rd_entry (rd_entry)
    );

    ofsa_count_ram u_cnt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (cnt_wr),
        .i_rd_addr (cnt_addr),
        .o_rd_data (cnt_data)
    );

    assign dsc_in_range = ({1'b0, r_dsc} < DLIM);
    assign cnt_addr     = (r_state == S_ESCAN) ? r_eaddr : r_ent;
    assign cnt_free     = r_pend && (cnt_data == '0);
    assign cnt_sat      = (cnt_data >= COUNT_MAX);
    // A close of a count of one or zero releases the entry.
    assign cnt_last     = (cnt_data <= COUNT_W'(1));

    // Table updates happen only in the cycle that finishes a command.
    always_comb begin
        map_wr = '0;
        cnt_wr = '0;
        case (r_state)
            S_CWAIT: begin
                if (r_cmd == CMD_DUP) begin
                    if (!cnt_sat) begin
                        map_wr = '{en: 1'b1, idx: r_dfree, valid: 1'b1, entry: r_ent};
                        cnt_wr = '{en: 1'b1, addr: r_ent, data: cnt_data + COUNT_W'(1)};
                    end
                end else begin
                    map_wr = '{en: 1'b1, idx: r_dsc[DIDX_W-1:0], valid: 1'b0, entry: '0};
                    cnt_wr = '{en: 1'b1, addr: r_ent,
                               data: cnt_last ? '0 : cnt_data - COUNT_W'(1)};
                end
            end
            S_ESCAN: begin
                if (cnt_free) begin
                    map_wr = '{en: 1'b1, idx: r_dfree, valid: 1'b1, entry: r_pend_addr};
                    cnt_wr = '{en: 1'b1, addr: r_pend_addr, data: COUNT_W'(1)};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= 1'b0;
            r_next_start <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_command;
                        r_dsc   <= i_descriptor;
                        r_dscan <= '0;
                        r_state <= (i_command == CMD_OPEN) ? S_DSCAN : S_RESOLVE;
                    end
                end
                S_RESOLVE: begin
                    r_ent <= rd_entry;
                    if (!dsc_in_range || !rd_valid) begin
                        r_valid  <= 1'b1;
                        r_status <= ST_BADF;
                        r_dout   <= '0;
                        r_eout   <= '0;
                        r_last   <= 1'b0;
                        r_state  <= S_IDLE;
                    end else begin
                        case (r_cmd)
                            CMD_LOOKUP: begin
                                r_valid  <= 1'b1;
                                r_status <= ST_OK;
                                r_dout   <= '0;
                                r_eout   <= 6'(rd_entry);
                                r_last   <= 1'b0;
                                r_state  <= S_IDLE;
                            end
                            CMD_DUP:   r_state <= S_DSCAN;
                            default:   r_state <= S_CRD;
                        endcase
                    end
                end
                S_DSCAN: begin
                    // One descriptor slot is checked per cycle, lowest first.
                    if (chk_free) begin
                        r_dfree <= r_dscan;
                        if (r_cmd == CMD_OPEN) begin
                            r_eaddr   <= r_next_start;
                            r_issue_k <= '0;
                            r_pend    <= 1'b0;
                            r_state   <= S_ESCAN;
                        end else begin
                            r_state <= S_CRD;
                        end
                    end else if (r_dscan == DLAST) begin
                        r_valid  <= 1'b1;
                        r_status <= ST_NODESC;
                        r_dout   <= '0;
                        r_eout   <= '0;
                        r_last   <= 1'b0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_dscan <= r_dscan + DIDX_W'(1);
                    end
                end
                S_CRD: begin
                    // The count of r_ent is read here and shows up next cycle.
                    r_state <= S_CWAIT;
                end
                S_CWAIT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                    if (r_cmd == CMD_DUP) begin
                        r_status <= cnt_sat ? ST_FULL : ST_OK;
                        r_dout   <= cnt_sat ? '0 : 5'(r_dfree);
                        r_eout   <= cnt_sat ? '0 : 6'(r_ent);
                        r_last   <= 1'b0;
                    end else begin
                        r_status <= ST_OK;
                        r_dout   <= '0;
                        r_eout   <= 6'(r_ent);
                        r_last   <= cnt_last;
                    end
                end
                S_ESCAN: begin
                    // Next-fit search: each cycle checks the count read in the
                    // cycle before and issues the read of the following entry.
                    if (cnt_free) begin
                        r_next_start <= ent_inc(r_pend_addr);
                        r_valid      <= 1'b1;
                        r_status     <= ST_OK;
                        r_dout       <= 5'(r_dfree);
                        r_eout       <= 6'(r_pend_addr);
                        r_last       <= 1'b0;
                        r_state      <= S_IDLE;
                    end else if (!r_pend && (r_issue_k == ECOUNT)) begin
                        r_valid  <= 1'b1;
                        r_status <= ST_FULL;
                        r_dout   <= '0;
                        r_eout   <= '0;
                        r_last   <= 1'b0;
                        r_state  <= S_IDLE;
                    end else if (r_issue_k != ECOUNT) begin
                        r_pend      <= 1'b1;
                        r_pend_addr <= r_eaddr;
                        r_eaddr     <= ent_inc(r_eaddr);
                        r_issue_k   <= r_issue_k + IK_W'(1);
                    end else begin
                        r_pend <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_descriptor_out = r_dout;
    assign o_entry_out      = r_eout;
    assign o_last_close     = r_last;

    // A result word only ever ends a command that was running.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result word without a running command");

    // An accepted command keeps the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // The last-close flag belongs to a successful close only.
    a_last_close_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_close) |-> (o_status == ST_OK && o_descriptor_out == 5'd0))
        else $error("last close flagged on a failed or allocating command");

    // The entry scan never issues more reads than the table has entries.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ESCAN) |-> (r_issue_k <= ECOUNT))
        else $error("entry scan ran past the table");

endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the open file slot allocator.
//
// Commands are driven on the start/busy handshake and every accepted command
// word is run through a behavioral copy of the descriptor map, the reference
// counts and the next-fit pointer kept in this module. The predicted result
// word is queued at the accepting edge and compared field by field with the
// next word that the block marks with o_valid. A short scripted sequence runs
// first, then three random stretches with different amounts of sender idling.
module tb_top;

    import ofsa_pkg::*;

    // The final drain waits longer than the slowest command (open with a deep
    // scan) can take.
    localparam int DRAIN_CYCLES = DESCRIPTORS + FILE_ENTRIES + 30;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int STRETCH_LEN  = 340;
    localparam int SCRIPT_LEN   = 20;

    // One result word as the block reports it.
    typedef struct packed {
        t_status    st;
        logic [4:0] dsc;
        logic [5:0] ent;
        logic       last;
    } t_fd_result;

    // One row of the scripted sequence. A row is sent reps times; with
    // reopen set, every send is followed by an open that is left to the
    // predictor. With pin set, the expected word is the one typed in here.
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] dsc;
        logic [6:0] reps;
        logic       reopen;
        logic       pin;
        t_fd_result want;
    } t_script_row;

    localparam t_fd_result BADF_WORD   = {ST_BADF, 5'd0, 6'd0, 1'b0};
    localparam t_fd_result NODESC_WORD = {ST_NODESC, 5'd0, 6'd0, 1'b0};
    localparam t_fd_result FREE_WORD   = '0;

    // The scripted sequence walks through the error cases on an empty table,
    // the first allocations, a shared entry and its last close, the next-fit
    // search skipping a freed low entry, a full descriptor map, and a churn
    // of close/open pairs that carries the search pointer past the top entry
    // and back to zero.
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        '{CMD_LOOKUP, 8'd0,   7'd1,  1'b0, 1'b1, BADF_WORD},
        '{CMD_DUP,    8'd0,   7'd1,  1'b0, 1'b1, BADF_WORD},
        '{CMD_CLOSE,  8'd31,  7'd1,  1'b0, 1'b1, BADF_WORD},
        '{CMD_LOOKUP, 8'd255, 7'd1,  1'b0, 1'b1, BADF_WORD},
        '{CMD_CLOSE,  8'd32,  7'd1,  1'b0, 1'b1, BADF_WORD},
        '{CMD_OPEN,   8'd0,   7'd1,  1'b0, 1'b1, {ST_OK, 5'd0, 6'd0, 1'b0}},
        '{CMD_OPEN,   8'd255, 7'd1,  1'b0, 1'b1, {ST_OK, 5'd1, 6'd1, 1'b0}},
        '{CMD_LOOKUP, 8'd1,   7'd1,  1'b0, 1'b1, {ST_OK, 5'd0, 6'd1, 1'b0}},
        '{CMD_DUP,    8'd0,   7'd1,  1'b0, 1'b1, {ST_OK, 5'd2, 6'd0, 1'b0}},
        '{CMD_CLOSE,  8'd0,   7'd1,  1'b0, 1'b1, {ST_OK, 5'd0, 6'd0, 1'b0}},
        '{CMD_CLOSE,  8'd2,   7'd1,  1'b0, 1'b1, {ST_OK, 5'd0, 6'd0, 1'b1}},
        '{CMD_LOOKUP, 8'd2,   7'd1,  1'b0, 1'b1, BADF_WORD},
        '{CMD_OPEN,   8'd0,   7'd1,  1'b0, 1'b1, {ST_OK, 5'd0, 6'd2, 1'b0}},
        '{CMD_OPEN,   8'd0,   7'd30, 1'b0, 1'b0, FREE_WORD},
        '{CMD_OPEN,   8'd0,   7'd1,  1'b0, 1'b1, NODESC_WORD},
        '{CMD_DUP,    8'd31,  7'd1,  1'b0, 1'b1, NODESC_WORD},
        '{CMD_CLOSE,  8'd0,   7'd32, 1'b1, 1'b0, FREE_WORD},
        '{CMD_LOOKUP, 8'd0,   7'd1,  1'b0, 1'b1, {ST_OK, 5'd0, 6'd0, 1'b0}},
        '{CMD_CLOSE,  8'd31,  7'd1,  1'b0, 1'b1, {ST_OK, 5'd0, 6'd32, 1'b1}},
        '{CMD_DUP,    8'd1,   7'd1,  1'b0, 1'b1, {ST_OK, 5'd31, 6'd1, 1'b0}}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_cmd       i_command;
    logic [7:0] i_descriptor;
    logic       o_valid;
    t_status    o_status;
    logic [4:0] o_descriptor_out;
    logic [5:0] o_entry_out;
    logic       o_last_close;

    // A typed-in expectation travels with the command word it belongs to.
    logic       pin_en;
    t_fd_result pin_word;

    // Predicted state of the allocator.
    logic              map_valid [DESCRIPTORS];
    logic [EIDX_W-1:0] map_entry [DESCRIPTORS];
    logic [COUNT_W-1:0] ref_cnt  [FILE_ENTRIES];
    int                search_from;

    t_fd_result awaited_results [$];
    int         err_cnt;
    int         cycle_cnt;

    open_file_slot_allocator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_descriptor    (i_descriptor),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_descriptor_out(o_descriptor_out),
        .o_entry_out     (o_entry_out),
        .o_last_close    (o_last_close)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Applies one command word to the predicted state and returns the word
    // the block should answer with. Checks run in the block's order: the
    // descriptor first, then a free descriptor, then the entry table or count.
    function automatic t_fd_result next_fd_result(t_cmd cmd, logic [7:0] dsc);
        t_fd_result        r;
        int                free_fd;
        int                ent;
        int                slot;
        logic              bad;
        logic [DIDX_W-1:0] idx;
        r       = '0;
        r.st    = ST_OK;
        idx     = dsc[DIDX_W-1:0];
        bad     = (dsc >= DESCRIPTORS) || !map_valid[idx];
        free_fd = -1;
        for (int k = 0; k < DESCRIPTORS; k++) begin
            if (free_fd < 0 && !map_valid[k]) free_fd = k;
        end
        case (cmd)
            CMD_OPEN: begin
                if (free_fd < 0) begin
                    r.st = ST_NODESC;
                end else begin
                    // Next-fit: start after the last entry given out, wrap once.
                    ent = -1;
                    for (int k = 0; k < FILE_ENTRIES; k++) begin
                        slot = (search_from + k) % FILE_ENTRIES;
                        if (ent < 0 && ref_cnt[slot] == 0) ent = slot;
                    end
                    if (ent < 0) begin
                        r.st = ST_FULL;
                    end else begin
                        search_from        = (ent + 1) % FILE_ENTRIES;
                        ref_cnt[ent]       = COUNT_W'(1);
                        map_valid[free_fd] = 1'b1;
                        map_entry[free_fd] = EIDX_W'(ent);
                        r.dsc              = 5'(free_fd);
                        r.ent              = 6'(ent);
                    end
                end
            end
            CMD_LOOKUP: begin
                if (bad) r.st = ST_BADF;
                else     r.ent = map_entry[idx];
            end
            CMD_DUP: begin
                if (bad) begin
                    r.st = ST_BADF;
                end else if (free_fd < 0) begin
                    r.st = ST_NODESC;
                end else if (ref_cnt[map_entry[idx]] >= COUNT_MAX) begin
                    r.st = ST_FULL;
                end else begin
                    ent                = map_entry[idx];
                    ref_cnt[ent]       = ref_cnt[ent] + 1'b1;
                    map_valid[free_fd] = 1'b1;
                    map_entry[free_fd] = EIDX_W'(ent);
                    r.dsc              = 5'(free_fd);
                    r.ent              = 6'(ent);
                end
            end
            default: begin
                if (bad) begin
                    r.st = ST_BADF;
                end else begin
                    ent            = map_entry[idx];
                    map_valid[idx] = 1'b0;
                    map_entry[idx] = '0;
                    // A zero count is treated like the last reference.
                    if (ref_cnt[ent] > 1) begin
                        ref_cnt[ent] = ref_cnt[ent] - 1'b1;
                    end else begin
                        ref_cnt[ent] = '0;
                        r.last       = 1'b1;
                    end
                    r.ent = 6'(ent);
                end
            end
        endcase
        return r;
    endfunction

    // Command mix for the random part. Fill stretches drive the map into
    // the no-free-descriptor case, drain stretches empty it again.
    function automatic t_cmd pick_command(int mix);
        int roll;
        roll = $urandom_range(99);
        case (mix)
            0:       return (roll < 45) ? CMD_OPEN : (roll < 65) ? CMD_DUP :
                            (roll < 85) ? CMD_LOOKUP : CMD_CLOSE;
            1:       return (roll < 15) ? CMD_OPEN : (roll < 25) ? CMD_DUP :
                            (roll < 45) ? CMD_LOOKUP : CMD_CLOSE;
            default: return (roll < 28) ? CMD_OPEN : (roll < 45) ? CMD_DUP :
                            (roll < 70) ? CMD_LOOKUP : CMD_CLOSE;
        endcase
    endfunction

    // Mostly a descriptor that is open right now, else any value in the
    // table's range or anywhere in the 8-bit field.
    function automatic logic [7:0] pick_descriptor();
        int live [$];
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) begin
            for (int k = 0; k < DESCRIPTORS; k++) begin
                if (map_valid[k]) live.push_back(k);
            end
            if (live.size() != 0) return 8'(live[$urandom_range(live.size() - 1)]);
        end
        if (roll < 85) return 8'($urandom_range(DESCRIPTORS - 1));
        return 8'($urandom_range(255));
    endfunction

    // Sends one command word and returns at the edge that accepts it. The
    // caller is always at a rising edge, so start gets one assignment per edge.
    task automatic issue_word(t_cmd cmd, logic [7:0] dsc, logic pin, t_fd_result want,
                              int idle_pct);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct) begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(21, 110) : $urandom_range(1, 20);
        end
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_command    <= cmd;
        i_descriptor <= dsc;
        pin_en       <= pin;
        pin_word     <= want;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Drops start and holds off until every expected word has come back.
    // The queue is polled on the falling edge, away from the checker.
    task automatic wait_results_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (awaited_results.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic run_stretch(int idle_pct);
        int         mix;
        t_cmd       cmd;
        logic [7:0] dsc;
        mix = 2;
        for (int n = 0; n < STRETCH_LEN; n++) begin
            if (n % 40 == 0) mix = $urandom_range(2);
            cmd = pick_command(mix);
            dsc = (cmd == CMD_OPEN) ? 8'($urandom_range(255)) : pick_descriptor();
            issue_word(cmd, dsc, 1'b0, FREE_WORD, idle_pct);
        end
    endtask

    // Prediction at the accepting edge and checking at the result strobe both
    // live here, so the queue is never touched by two processes in one step.
    always @(posedge i_clk) begin
        t_fd_result want;
        t_fd_result got;
        if (i_rst_n && start && !busy) begin
            want = next_fd_result(i_command, i_descriptor);
            if (pin_en) want = pin_word;
            awaited_results.push_back(want);
        end
        if (i_rst_n && o_valid) begin
            got = {o_status, o_descriptor_out, o_entry_out, o_last_close};
            if (awaited_results.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) begin
                    $display("unexpected result word: st=%0d dsc=%0d ent=%0d last=%0d",
                             got.st, got.dsc, got.ent, got.last);
                end
            end else begin
                want = awaited_results.pop_front();
                if (got !== want) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("result mismatch: expected st=%0d dsc=%0d ent=%0d last=%0d, got st=%0d dsc=%0d ent=%0d last=%0d",
                                 want.st, want.dsc, want.ent, want.last,
                                 got.st, got.dsc, got.ent, got.last);
                    end
                end
            end
        end
    end

    // Hard stop in case the block hangs or drops a result.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        err_cnt      = 0;
        cycle_cnt    = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_command    = CMD_OPEN;
        i_descriptor = '0;
        pin_en       = 1'b0;
        pin_word     = FREE_WORD;
        for (int k = 0; k < DESCRIPTORS; k++) begin
            map_valid[k] = 1'b0;
            map_entry[k] = '0;
        end
        for (int k = 0; k < FILE_ENTRIES; k++) ref_cnt[k] = '0;
        search_from = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Scripted part, sent back to back.
        for (int i = 0; i < SCRIPT_LEN; i++) begin
            for (int rep = 0; rep < SCRIPT[i].reps; rep++) begin
                issue_word(SCRIPT[i].cmd, SCRIPT[i].dsc, SCRIPT[i].pin, SCRIPT[i].want, 0);
                if (SCRIPT[i].reopen) issue_word(CMD_OPEN, 8'd0, 1'b0, FREE_WORD, 0);
            end
        end
        wait_results_drained();

        // Random part: moderate sender idling, then heavy, then none. The
        // sender also waits for the block to go quiet between stretches.
        run_stretch(30);
        wait_results_drained();
        run_stretch(54);
        wait_results_drained();
        run_stretch(0);
        wait_results_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        err_cnt += awaited_results.size();
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
